/* design/rsv_pkg.sv */
// rsv_pkg: shared types and constants for the reservoir sampler.
// Used by rsv_pick and reservoir_sampler; no dependencies of its own.
package rsv_pkg;

   // Default build parameters
   localparam int DefMaxSlots  = 16;
   localparam int DefValueBits = 32;

   // Fixed field widths
   localparam int DataBits  = 32;
   localparam int FracBits  = 32;
   localparam int CountBits = 32;
   localparam int SizeBits  = 7;
   localparam int SlotBits  = 6;

   localparam logic [SizeBits-1:0]  SizeReset = SizeBits'(16);
   localparam logic [CountBits-1:0] CountMax  = '1;

   // Control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_DUMP,
      ST_FLUSH
   } state_type;

   // Slot decision for one item
   typedef struct packed {
      logic                keep;
      logic [SizeBits-1:0] slot;
   } pick_type;

endpackage

/* design/rsv_ram.sv */
// rsv_ram: generic simple dual-port RAM, one write and one registered read port.
// Read data holds its value while no read is issued. No dependencies.
module rsv_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* design/rsv_pick.sv */
// rsv_pick: chooses the reservoir slot for one item (fill order or scaled random draw).
// Depends on rsv_pkg.
module rsv_pick
   import rsv_pkg::*;
(
   input  logic [FracBits-1:0]  frac,
   input  logic [CountBits-1:0] count,
   input  logic                 fill,
   input  logic [SizeBits-1:0]  fill_slot,
   input  logic [SizeBits-1:0]  size,
   output pick_type             pick
);

   logic [FracBits+CountBits-1:0] product;
   logic [CountBits-1:0]          slot_wide;

   // floor(frac * n / 2^32), or the next slot in fill order
   always_comb begin
      product   = (FracBits+CountBits)'(frac) * (FracBits+CountBits)'(count);
      slot_wide = fill ? CountBits'(fill_slot) : product[FracBits+CountBits-1:FracBits];
      pick.keep = slot_wide < CountBits'(size);
      pick.slot = slot_wide[SizeBits-1:0];
   end

endmodule

/* design/reservoir_sampler.sv */
// reservoir_sampler: uniform reservoir sampling of a stream (Algorithm R).
// Depends on rsv_pkg, rsv_pick and rsv_ram.
//
// Usage
//   req_*  : one stream item per transfer (value, random fraction, end marker).
//   rsp_*  : kept slots, emitted in slot order after the item flagged stream_end.
//   csr_*  : write of reservoir_size (0 acts as 1, above MAX_SLOTS as MAX_SLOTS);
//            write only while the block is idle.
// Timing
//   An item is taken, then written to the slot store in the following cycle. The next
//   item may be taken in that write cycle, so items stream at one per cycle.
//   The item with stream_end closes the stream: ready drops, and after its write
//   the dump state reads slots into the registered result (a short stream skips it).
//   A full reservoir gives one result per cycle while rsp_ready is high, limited
//   by the single read port of the slot store; a stream that ended before the
//   reservoir filled gives a single result flagged short_stream. Input is taken
//   again in the cycle after the last result transfers.
// Reset
//   Clears the item count, the written flags and the output valid, and sets the
//   size register to 16. The slot store itself is not cleared.
// Stalls
//   While rsp_ready is low the current result holds and no further slot is read.
module reservoir_sampler
   import rsv_pkg::*;
#(
   parameter int MAX_SLOTS  = DefMaxSlots,
   parameter int VALUE_BITS = DefValueBits
) (
   input  logic                clock,
   input  logic                reset,
   // item channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [DataBits-1:0] req_sample_value,
   input  logic [FracBits-1:0] req_random_fraction,
   input  logic                req_stream_end,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DataBits-1:0] rsp_kept_value,
   output logic [SlotBits-1:0] rsp_slot_number,
   output logic                rsp_final_result,
   output logic                rsp_short_stream,
   // size register
   input  logic                csr_write_enable,
   input  logic [SizeBits-1:0] csr_write_data
);

   localparam int StoreBits = (VALUE_BITS < DataBits) ? VALUE_BITS : DataBits;
   localparam int AddrBits  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam logic [SizeBits-1:0] MaxSize = SizeBits'(MAX_SLOTS);

   state_type              state_ff, state_in;
   logic [CountBits-1:0]   items_seen_ff, items_seen_in;
   logic [MAX_SLOTS-1:0]   written_ff, written_in;
   logic [SizeBits-1:0]    size_ff, size_in;
   logic [StoreBits-1:0]   value_ff, value_in;
   logic [FracBits-1:0]    frac_ff, frac_in;
   logic                   last_ff, last_in;
   logic                   fill_ff, fill_in;
   logic [SizeBits-1:0]    fill_slot_ff, fill_slot_in;
   logic [SizeBits-1:0]    rd_idx_ff, rd_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SlotBits-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                   rsp_final_ff, rsp_final_in;
   logic                   rsp_short_ff, rsp_short_in;

   logic                   req_fire;
   logic [SizeBits-1:0]    size_eff;
   logic [CountBits-1:0]   count_next;
   logic [SizeBits-1:0]    rd_idx_next;
   pick_type               pick;
   logic                   do_write;
   logic [MAX_SLOTS-1:0]   written_upd;
   logic                   all_written;
   logic                   ram_rd_en;
   logic [StoreBits-1:0]   ram_rd_data;
   logic                   last_slot;

   // Effective size: 0 acts as 1, clamped to the built depth
   always_comb begin
      if (size_ff == '0) begin
         size_eff = SizeBits'(1);
      end else if (size_ff > MaxSize) begin
         size_eff = MaxSize;
      end else begin
         size_eff = size_ff;
      end
   end

   // Slot choice for the item in the write stage
   rsv_pick u_pick (
      .frac      (frac_ff),
      .count     (items_seen_ff),
      .fill      (fill_ff),
      .fill_slot (fill_slot_ff),
      .size      (size_eff),
      .pick      (pick)
   );

   // Slot store
   rsv_ram #(
      .WIDTH (StoreBits),
      .DEPTH (MAX_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (pick.slot[AddrBits-1:0]),
      .wr_data (value_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff[AddrBits-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_WRITE) && !last_ff);
   assign req_fire  = req_valid && req_ready;
   assign do_write  = (state_ff == ST_WRITE) && pick.keep;

   // Saturating running count, including the incoming item
   assign count_next  = (items_seen_ff == CountMax) ? CountMax : items_seen_ff + 1'b1;
   assign rd_idx_next = rd_idx_ff + SizeBits'(1);
   assign last_slot   = (rd_idx_next == size_eff);

   // Written flags with this cycle's write folded in; full check below size
   always_comb begin
      all_written = 1'b1;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         written_upd[i] = written_ff[i] || (do_write && (pick.slot == SizeBits'(i)));
         if (!written_upd[i] && (SizeBits'(i) < size_eff)) begin
            all_written = 1'b0;
         end
      end
   end

   // Next state and datapath
   always_comb begin
      state_in      = state_ff;
      items_seen_in = items_seen_ff;
      written_in    = written_ff;
      size_in       = size_ff;
      value_in      = value_ff;
      frac_in       = frac_ff;
      last_in       = last_ff;
      fill_in       = fill_ff;
      fill_slot_in  = fill_slot_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_final_in  = rsp_final_ff;
      rsp_short_in  = rsp_short_ff;
      ram_rd_en     = 1'b0;

      if (csr_write_enable) begin
         size_in = csr_write_data;
      end

      // Capture an item and count it
      if (req_fire) begin
         value_in      = req_sample_value[StoreBits-1:0];
         frac_in       = req_random_fraction;
         last_in       = req_stream_end;
         fill_in       = items_seen_ff < CountBits'(size_eff);
         fill_slot_in  = items_seen_ff[SizeBits-1:0];
         items_seen_in = count_next;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            written_in = written_upd;
            if (last_ff) begin
               // stream closed: start a new one, then dump or flag short
               items_seen_in = '0;
               written_in    = '0;
               rd_idx_in     = '0;
               if (all_written) begin
                  state_in = ST_DUMP;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = '0;
                  rsp_final_in = 1'b1;
                  rsp_short_in = 1'b1;
                  state_in     = ST_FLUSH;
               end
            end else if (!req_fire) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            // read the next slot whenever the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               ram_rd_en    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_slot_in  = rd_idx_ff[SlotBits-1:0];
               rsp_final_in = last_slot;
               rsp_short_in = 1'b0;
               rd_idx_in    = rd_idx_next;
               if (last_slot) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         items_seen_ff <= '0;
         written_ff    <= '0;
         size_ff       <= SizeReset;
         rd_idx_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         last_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         items_seen_ff <= items_seen_in;
         written_ff    <= written_in;
         size_ff       <= size_in;
         rd_idx_ff     <= rd_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_ff       <= last_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      frac_ff      <= frac_in;
      fill_ff      <= fill_in;
      fill_slot_ff <= fill_slot_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_final_ff <= rsp_final_in;
      rsp_short_ff <= rsp_short_in;
   end

   // Outputs
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kept_value   = rsp_short_ff ? '0 : DataBits'(ram_rd_data);
   assign rsp_slot_number  = rsp_slot_ff;
   assign rsp_final_result = rsp_final_ff;
   assign rsp_short_stream = rsp_short_ff;

   // Checks
   a_rsp_only_in_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((state_ff == ST_DUMP) || (state_ff == ST_FLUSH)))
      else $error("result valid outside a dump");

   a_final_ends_dump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_final_result) |=> (state_ff == ST_IDLE))
      else $error("final result transfer did not end the dump");

   a_short_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_short_stream) |-> (rsp_final_result && (rsp_slot_number == '0)))
      else $error("short-stream result malformed");

   a_dump_counts_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> ((items_seen_ff == '0) && (written_ff == '0)))
      else $error("stream state not cleared during dump");

   a_dump_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> (rd_idx_ff < size_eff))
      else $error("dump read index beyond reservoir size");

endmodule
